/* hdl/melody_note_sequencer_defines.svh */
// Assertion macros shared by the melody note sequencer RTL.
// Depends on nothing; the using scope must provide clock and reset.
`ifndef MELODY_NOTE_SEQUENCER_DEFINES_SVH
`define MELODY_NOTE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MNS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("melody_note_sequencer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MNS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("melody_note_sequencer: next-cycle check failed");

`endif

/* hdl/mns_pkg.sv */
// Shared constants, codes and control structs of the melody note sequencer.
// Depends on nothing.
package mns_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = 8;

   localparam logic [21:0] ELAPSED_MAX = 22'h3FFFFF;

   // Request type codes.
   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_WRITE   = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_WHOLE_NOTE  = 2'd0;
   localparam logic [1:0] CSR_SPEED       = 2'd1;
   localparam logic [1:0] CSR_SONG_LENGTH = 2'd2;

   localparam logic [15:0] WHOLE_NOTE_RESET = 16'd1967;
   localparam logic [11:0] SPEED_RESET      = 12'd256;

   typedef struct packed {
      logic [15:0] whole_note_ms;
      logic [11:0] speed_q8;
      logic [8:0]  song_length;
   } mns_cfg_type;

   typedef struct packed {
      logic accept;
      logic write;
      logic restart;
      logic inc;
      logic load;
      logic div_step;
      logic dot;
      logic mul;
      logic cmp;
      logic resp;
   } mns_cmd_type;

   typedef struct packed {
      logic start_ok;
      logic div_nz;
      logic div_last;
      logic rsp_free;
   } mns_status_type;

endpackage

/* hdl/mns_channels.sv */
// Request and response channel interfaces of the melody note sequencer.
// Depends on nothing.
interface mns_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [7:0]        entry_index;
   logic [15:0]       entry_pitch;
   logic signed [6:0] entry_divider;

   modport source (output valid, req_type, entry_index, entry_pitch, entry_divider,
                   input ready);
   modport sink   (input valid, req_type, entry_index, entry_pitch, entry_divider,
                   output ready);
endinterface

interface mns_rsp_if;
   logic        valid;
   logic        ready;
   logic        tone_on;
   logic [15:0] tone_freq;
   logic [7:0]  note_position;
   logic        note_started;

   modport source (output valid, tone_on, tone_freq, note_position, note_started,
                   input ready);
   modport sink   (input valid, tone_on, tone_freq, note_position, note_started,
                   output ready);
endinterface

/* hdl/melody_note_sequencer.sv */
// Melody note sequencer top level. One request at a time: a write, restart or unused
// request goes straight to the response state; a tick runs increment, multiply, compare
// and response, plus a table read when a note starts and the 16-step divider when its
// divider is nonzero. A new request is taken once the response is loaded, even if unread.
// Reset (synchronous, active high) clears playback state and restores register defaults;
// the note tables are not cleared and hold undefined data until written.
`include "melody_note_sequencer_defines.svh"

module melody_note_sequencer
   import mns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mns_req_if.sink     req_if,
   mns_rsp_if.source   rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   mns_cfg_type    cfg;
   mns_cmd_type    cmd;
   mns_status_type status;

   // The register block holds the tempo, the speed factor and the song length.
   mns_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // The controller steps a tick through increment, table read, division,
   // length update, multiply, end-of-note compare and response as needed; other requests go straight to response.
   mns_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the tables, the playback state and the response register,
   // so a finished response can wait while the next request is taken.
   mns_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cfg               (cfg),
      .entry_index       (req_if.entry_index),
      .entry_pitch       (req_if.entry_pitch),
      .entry_divider     (req_if.entry_divider),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_tone_on       (rsp_if.tone_on),
      .rsp_tone_freq     (rsp_if.tone_freq),
      .rsp_note_position (rsp_if.note_position),
      .rsp_note_started  (rsp_if.note_started)
   );

   // A sounding tone always carries a nonzero frequency.
   `MNS_ASSERT_NOW(a_tone_has_freq, rsp_if.valid && rsp_if.tone_on, rsp_if.tone_freq != 16'd0)
   // Once a request is taken, the block is busy on the next cycle.
   `MNS_ASSERT_NEXT(a_busy_after_accept, req_if.valid && req_if.ready, !req_if.ready)
   // Loading the response register always presents a response.
   `MNS_ASSERT_NEXT(a_resp_presented, cmd.resp, rsp_if.valid)

endmodule

/* hdl/mns_csr.sv */
// Configuration registers of the melody note sequencer behind an APB-style port.
// Depends on mns_pkg.
module mns_csr
   import mns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output mns_cfg_type cfg
);

   mns_cfg_type cfg_ff, cfg_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            CSR_WHOLE_NOTE:  cfg_in.whole_note_ms = pwdata[15:0];
            CSR_SPEED:       cfg_in.speed_q8      = pwdata[11:0];
            CSR_SONG_LENGTH: cfg_in.song_length   = pwdata[8:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_WHOLE_NOTE:  prdata = {16'd0, cfg_ff.whole_note_ms};
         CSR_SPEED:       prdata = {20'd0, cfg_ff.speed_q8};
         CSR_SONG_LENGTH: prdata = {23'd0, cfg_ff.song_length};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.whole_note_ms <= WHOLE_NOTE_RESET;
         cfg_ff.speed_q8      <= SPEED_RESET;
         cfg_ff.song_length   <= 9'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/mns_datapath.sv */
// Datapath of the melody note sequencer: note tables, playback state, the
// iterative note-length divider, the end-of-note multiplier and the response register.
// Depends on mns_pkg.
module mns_datapath
   import mns_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mns_cmd_type       cmd,
   output mns_status_type    status,
   input  mns_cfg_type       cfg,
   input  logic [7:0]        entry_index,
   input  logic [15:0]       entry_pitch,
   input  logic signed [6:0] entry_divider,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              rsp_tone_on,
   output logic [15:0]       rsp_tone_freq,
   output logic [7:0]        rsp_note_position,
   output logic              rsp_note_started
);

   logic [15:0] pitch_mem_ff [TABLE_DEPTH];
   logic [6:0]  div_mem_ff   [TABLE_DEPTH];
   logic [15:0] rd_pitch_ff;
   logic [6:0]  rd_div_ff;

   logic [ADDR_W-1:0] position_ff, position_in;
   logic        playing_ff, playing_in;
   logic [21:0] elapsed_ff, elapsed_in;
   logic [16:0] length_ff, length_in;
   logic [15:0] pitch_ff, pitch_in;
   logic        started_ff, started_in;

   logic [15:0] dvd_ff, dvd_in;
   logic [15:0] quo_ff, quo_in;
   logic [6:0]  rem_ff, rem_in;
   logic [6:0]  mag_ff, mag_in;
   logic        dotted_ff, dotted_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [28:0] prod_ff, prod_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        tone_on_ff, tone_on_in;
   logic [15:0] tone_freq_ff;
   logic [7:0]  note_pos_ff;
   logic        note_started_ff;

   logic [7:0]  trial;
   logic        fits;
   logic [7:0]  pos_step;
   logic        note_end;
   logic [22:0] elapsed_p1;
   logic [25:0] elapsed_x10;
   logic [20:0] length_x9;

   assign status.start_ok = !playing_ff && ({1'b0, position_ff} < cfg.song_length);
   assign status.div_nz   = (rd_div_ff != 7'd0);
   assign status.div_last = (cnt_ff == 4'd15);
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   // One restoring division step a cycle, most significant dividend bit first.
   assign trial = {rem_ff, dvd_ff[15]};
   assign fits  = (trial >= {1'b0, mag_ff});

   assign note_end = playing_ff && ({elapsed_ff, 8'h00} >= {1'b0, prod_ff});
   assign pos_step = note_end ? position_ff + 8'd1 : position_ff;

   // elapsed < floor(9L/10) is the same as 10*(elapsed+1) <= 9L.
   assign elapsed_p1  = {1'b0, elapsed_ff} + 23'd1;
   assign elapsed_x10 = {elapsed_p1, 3'b000} + {2'b00, elapsed_p1, 1'b0};
   assign length_x9   = {1'b0, length_ff, 3'b000} + {4'b0000, length_ff};

   always_comb begin
      position_in  = position_ff;
      playing_in   = playing_ff;
      elapsed_in   = elapsed_ff;
      length_in    = length_ff;
      pitch_in     = pitch_ff;
      started_in   = started_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      mag_in       = mag_ff;
      dotted_in    = dotted_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tone_on_in   = playing_ff && (pitch_ff != 16'd0)
                     && (elapsed_x10 <= {5'd0, length_x9});

      if (cmd.accept) begin
         started_in = 1'b0;
      end
      if (cmd.restart) begin
         position_in = '0;
         playing_in  = 1'b0;
         elapsed_in  = 22'd0;
      end
      if (cmd.inc && playing_ff && (elapsed_ff != ELAPSED_MAX)) begin
         elapsed_in = elapsed_ff + 22'd1;
      end
      if (cmd.load) begin
         pitch_in   = rd_pitch_ff;
         elapsed_in = 22'd0;
         playing_in = 1'b1;
         started_in = 1'b1;
         dvd_in     = cfg.whole_note_ms;
         quo_in     = 16'd0;
         rem_in     = 7'd0;
         cnt_in     = 4'd0;
         dotted_in  = rd_div_ff[6];
         mag_in     = rd_div_ff[6] ? 7'd0 - rd_div_ff : rd_div_ff;
      end
      if (cmd.div_step) begin
         rem_in = fits ? 7'(trial - {1'b0, mag_ff}) : trial[6:0];
         quo_in = {quo_ff[14:0], fits};
         dvd_in = {dvd_ff[14:0], 1'b0};
         cnt_in = cnt_ff + 4'd1;
      end
      if (cmd.dot) begin
         length_in = {1'b0, quo_ff} + (dotted_ff ? {2'b00, quo_ff[15:1]} : 17'd0);
      end
      if (cmd.mul) begin
         prod_in = {12'd0, length_ff} * {17'd0, cfg.speed_q8};
      end
      if (cmd.cmp) begin
         if (note_end) begin
            playing_in = 1'b0;
         end
         position_in = ({1'b0, pos_step} >= cfg.song_length) ? '0 : pos_step;
      end
      if (cmd.resp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         pitch_mem_ff[entry_index] <= entry_pitch;
         div_mem_ff[entry_index]   <= entry_divider;
      end
      rd_pitch_ff <= pitch_mem_ff[position_ff];
      rd_div_ff   <= div_mem_ff[position_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         playing_ff   <= 1'b0;
         elapsed_ff   <= 22'd0;
         length_ff    <= 17'd0;
         pitch_ff     <= 16'd0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         playing_ff   <= playing_in;
         elapsed_ff   <= elapsed_in;
         length_ff    <= length_in;
         pitch_ff     <= pitch_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      mag_ff    <= mag_in;
      dotted_ff <= dotted_in;
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      if (cmd.resp) begin
         tone_on_ff      <= tone_on_in;
         tone_freq_ff    <= pitch_ff;
         note_pos_ff     <= position_ff;
         note_started_ff <= started_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tone_on       = tone_on_ff;
   assign rsp_tone_freq     = tone_freq_ff;
   assign rsp_note_position = note_pos_ff;
   assign rsp_note_started  = note_started_ff;

endmodule

/* hdl/mns_controller.sv */
// Sequencing state machine of the melody note sequencer.
// Depends on mns_pkg; drives the datapath by command and reads its status.
module mns_controller
   import mns_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_type,
   output logic           req_ready,
   input  mns_status_type status,
   output mns_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_INC  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DOT  = 3'd4;
   localparam logic [2:0] ST_MUL  = 3'd5;
   localparam logic [2:0] ST_CMP  = 3'd6;
   localparam logic [2:0] ST_RESP = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept  = 1'b1;
               cmd.write   = (req_type == REQ_WRITE);
               cmd.restart = (req_type == REQ_RESTART);
               state_in    = (req_type == REQ_TICK) ? ST_INC : ST_RESP;
            end
         end
         ST_INC: begin
            cmd.inc  = 1'b1;
            state_in = status.start_ok ? ST_LOAD : ST_MUL;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = status.div_nz ? ST_DIV : ST_MUL;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            cmd.dot  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.resp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
